@@ design/nau_pkg.sv @@
// Package for the activation unit: mode codes, configuration struct,
// fixed-point constants and the sigmoid and density lookup tables.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package nau_pkg;

    // Activation selection codes. Code 7 is unused and passes the input through.
    typedef enum logic [2:0] {
        ACT_SIGMOID   = 3'd0,
        ACT_SIG_SNAP  = 3'd1,
        ACT_BOOL_SNAP = 3'd2,
        ACT_RELU      = 3'd3,
        ACT_LEAKY     = 3'd4,
        ACT_NOISY     = 3'd5,
        ACT_PRELU     = 3'd6
    } act_mode_t;

    localparam int DATA_W  = 16;
    localparam int SHAPE_W = 10;

    typedef logic signed [DATA_W-1:0]  q78_t;
    typedef logic signed [SHAPE_W-1:0] shape_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        act_mode_t mode;
        shape_t    shape;
    } act_cfg_t;

    // Register indexes on the configuration port (address bit 2).
    localparam logic REG_ACT_MODE = 1'b0;
    localparam logic REG_SHAPE    = 1'b1;

    // Fixed-point constants in Q.8 unless stated otherwise.
    localparam int SIG_LAST  = 32;
    localparam int DEN_LAST  = 16;
    localparam int LEAK_NUM  = 655;       // leak slope in Q0.16
    localparam int SNAP_HIGH = 187;       // sigmoid(1)
    localparam int SNAP_LOW  = 128;       // sigmoid(0)
    localparam int ONE_Q8    = 256;

    // Sigmoid of 0, 0.25, ... 8.0 in Q0.16.
    localparam logic [15:0] SIG_ROM [0:SIG_LAST] = '{
        16'd32768, 16'd36843, 16'd40793, 16'd44511, 16'd47910, 16'd50941,
        16'd53581, 16'd55834, 16'd57724, 16'd59287, 16'd60565, 16'd61598,
        16'd62428, 16'd63090, 16'd63615, 16'd64030, 16'd64357, 16'd64614,
        16'd64816, 16'd64974, 16'd65097, 16'd65194, 16'd65269, 16'd65328,
        16'd65374, 16'd65410, 16'd65438, 16'd65459, 16'd65476, 16'd65489,
        16'd65500, 16'd65508, 16'd65514
    };

    // Standard normal density of 0, 0.25, ... 4.0 in Q0.16.
    localparam logic [15:0] DEN_ROM [0:DEN_LAST] = '{
        16'd26145, 16'd25341, 16'd23073, 16'd19735, 16'd15858, 16'd11970,
        16'd8488,  16'd5654,  16'd3538,  16'd2080,  16'd1149,  16'd596,
        16'd290,   16'd133,   16'd57,    16'd23,    16'd9
    };

endpackage

`default_nettype wire

@@ design/nau_stream_if.sv @@
// Valid/ready stream interfaces for the operand and result channels.
// Depends on nau_pkg for the Q7.8 payload type.
`timescale 1ns / 1ps
`default_nettype none

interface nau_operand_if;
    import nau_pkg::*;

    logic valid;
    logic ready;
    q78_t value_in;

    modport source (output valid, output value_in, input ready);
    modport sink   (input valid, input value_in, output ready);
endinterface

interface nau_result_if;
    import nau_pkg::*;

    logic valid;
    logic ready;
    q78_t value_out;

    modport source (output valid, output value_out, input ready);
    modport sink   (input valid, input value_out, output ready);
endinterface

`default_nettype wire

@@ design/nau_cfg_regs.sv @@
// APB-style register file holding the activation mode and shape parameter.
// Depends on nau_pkg for register indexes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module nau_cfg_regs
    import nau_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output act_cfg_t         cfg
);

    logic   [2:0] act_mode_reg;
    logic   [2:0] act_mode_next;
    shape_t       shape_reg;
    shape_t       shape_next;
    logic         wr_en;
    logic         reg_sel;

    // Registers are word aligned; the byte offset within a word is ignored.
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb
    begin
        act_mode_next = act_mode_reg;
        shape_next    = shape_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_ACT_MODE: act_mode_next = pwdata[2:0];
                REG_SHAPE:    shape_next    = $signed(pwdata[SHAPE_W-1:0]);
                default:      act_mode_next = act_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_mode_reg <= 3'd0;
            shape_reg    <= '0;
        end
        else
        begin
            act_mode_reg <= act_mode_next;
            shape_reg    <= shape_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ACT_MODE: prdata = {29'd0, act_mode_reg};
            REG_SHAPE:    prdata = {{(32-SHAPE_W){shape_reg[SHAPE_W-1]}}, shape_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.mode  = act_mode_t'(act_mode_reg);
    assign cfg.shape = shape_reg;

endmodule

`default_nettype wire

@@ design/nau_act_func.sv @@
// Combinational activation datapath: table interpolation, snapping, slopes
// and saturation for one Q7.8 value. Depends on nau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nau_act_func
    import nau_pkg::*;
(
    input  wire act_cfg_t cfg,
    input  wire q78_t     x,
    output q78_t          y
);

    // True when |centre - v| <= tol; a negative tolerance never matches.
    function automatic logic near(input logic signed [16:0] centre,
                                  input logic signed [16:0] v,
                                  input shape_t             tol);
        logic signed [17:0] d;
        logic signed [18:0] a;
        begin
            d = 18'(centre) - 18'(v);
            a = d[17] ? -19'(d) : 19'(d);
            near = a <= 19'(tol);
        end
    endfunction

    logic        [16:0] mag;
    logic               sig_sat;
    logic        [5:0]  sig_i;
    logic        [5:0]  sig_n;
    logic        [5:0]  frac;
    logic        [15:0] sig_base;
    logic        [11:0] sig_diff;
    logic        [17:0] sig_prod;
    logic        [22:0] sig_v;
    logic        [22:0] sig_signed_v;
    logic        [22:0] sig_rnd;
    logic        [8:0]  sig_q8;

    logic               den_sat;
    logic        [4:0]  den_i;
    logic        [4:0]  den_n;
    logic        [15:0] den_base;
    logic        [11:0] den_diff;
    logic        [17:0] den_prod;
    logic        [22:0] den_v;
    logic        [22:0] den_rnd;
    logic        [8:0]  den_q8;

    logic signed [16:0] x_wide;
    logic signed [16:0] sig_wide;
    logic signed [16:0] sig_snapped;
    logic signed [16:0] bool_snapped;

    logic signed [27:0] leak_prod;
    logic signed [27:0] leak_sum;
    logic signed [25:0] pr_prod;
    logic signed [26:0] pr_sum;
    logic signed [18:0] pr_shift;
    q78_t               pr_sat;

    logic signed [16:0] noisy_sum;
    q78_t               noisy_sat;

    assign x_wide = 17'(x);
    assign mag    = x[DATA_W-1] ? 17'(-x_wide) : 17'(x_wide);
    assign frac   = mag[5:0];

    // Sigmoid: table step of 0.25, linear interpolation in Q0.22.
    assign sig_sat  = mag[16:11] != 6'd0;
    assign sig_i    = sig_sat ? 6'(SIG_LAST) : {1'b0, mag[10:6]};
    assign sig_n    = sig_sat ? 6'(SIG_LAST) : 6'(sig_i + 6'd1);
    assign sig_base = SIG_ROM[sig_i];
    assign sig_diff = 12'(SIG_ROM[sig_n] - SIG_ROM[sig_i]);
    assign sig_prod = sig_diff * (sig_sat ? 6'd0 : frac);
    assign sig_v    = {1'b0, sig_base, 6'd0} + 23'(sig_prod);
    assign sig_signed_v = x[DATA_W-1] ? (23'd1 << 22) - sig_v : sig_v;
    assign sig_rnd  = sig_signed_v + 23'd8192;
    assign sig_q8   = sig_rnd[22:14];

    // Density is falling, so the step is subtracted.
    assign den_sat  = mag[16:10] != 7'd0;
    assign den_i    = den_sat ? 5'(DEN_LAST) : {1'b0, mag[9:6]};
    assign den_n    = den_sat ? 5'(DEN_LAST) : 5'(den_i + 5'd1);
    assign den_base = DEN_ROM[den_i];
    assign den_diff = 12'(DEN_ROM[den_i] - DEN_ROM[den_n]);
    assign den_prod = den_diff * (den_sat ? 6'd0 : frac);
    assign den_v    = {1'b0, den_base, 6'd0} - 23'(den_prod);
    assign den_rnd  = den_v + 23'd8192;
    assign den_q8   = den_rnd[22:14];

    assign sig_wide = 17'(sig_q8);

    always_comb
    begin
        if (near(17'(SNAP_HIGH), sig_wide, cfg.shape))
            sig_snapped = 17'(SNAP_HIGH);
        else if (near(17'(SNAP_LOW), sig_wide, cfg.shape))
            sig_snapped = 17'(SNAP_LOW);
        else
            sig_snapped = sig_wide;

        if (near(17'(ONE_Q8), x_wide, cfg.shape))
            bool_snapped = 17'(ONE_Q8);
        else if (near(17'sd0, x_wide, cfg.shape))
            bool_snapped = 17'sd0;
        else
            bool_snapped = x_wide;
    end

    // Leaky slope: round to nearest with ties upward; the result is always tiny.
    assign leak_prod = 28'(x) * 28'(LEAK_NUM);
    assign leak_sum  = leak_prod + 28'sd32768;

    // Parametric slope, saturated to 16 bits.
    assign pr_prod  = 26'(x) * 26'(cfg.shape);
    assign pr_sum   = 27'(pr_prod) + 27'sd128;
    assign pr_shift = pr_sum[26:8];
    always_comb
    begin
        if (pr_shift > 19'sd32767)
            pr_sat = 16'sh7fff;
        else if (pr_shift < -19'sd32768)
            pr_sat = 16'sh8000;
        else
            pr_sat = pr_shift[15:0];
    end

    // Noisy ReLU: the density is never negative, so only the upper bound can be hit.
    assign noisy_sum = x_wide + 17'(den_q8);
    assign noisy_sat = (noisy_sum > 17'sd32767) ? 16'sh7fff : noisy_sum[15:0];

    always_comb
    begin
        case (cfg.mode)
            ACT_SIGMOID:   y = 16'(sig_q8);
            ACT_SIG_SNAP:  y = sig_snapped[15:0];
            ACT_BOOL_SNAP: y = bool_snapped[15:0];
            ACT_RELU:      y = (x > 16'sd0) ? x : 16'sd0;
            ACT_LEAKY:     y = (x > 16'sd0) ? x : 16'($signed(leak_sum[27:16]));
            ACT_NOISY:     y = (noisy_sat > 16'sd0) ? noisy_sat : 16'sd0;
            ACT_PRELU:     y = (x > 16'sd0) ? x : pr_sat;
            default:       y = x;
        endcase
    end

endmodule

`default_nettype wire

@@ design/neural_activation_unit_core.sv @@
// Top level of the activation unit: configuration port, operand register,
// activation datapath and result register. Depends on nau_pkg, the stream
// interfaces, nau_cfg_regs and nau_act_func.
// The result passes through the operand register and then the result
// register before it can transfer; a result stall holds it in either.
// Throughput: one value per cycle while results are taken, set by the
// single pass through the datapath between the two registers.
// Reset: asynchronous, active low; clears both valid flags, act_mode and
// shape_param. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module neural_activation_unit_core
    import nau_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    nau_operand_if.sink      operand,
    nau_result_if.source     result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    act_cfg_t cfg;

    // Stage one holds the operand; stage two holds the finished result.
    logic     in_valid_reg;
    logic     in_valid_next;
    q78_t     x_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    q78_t     y_reg;
    q78_t     y_next;

    logic     out_free;
    logic     in_free;
    logic     take_in;

    nau_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nau_act_func u_func (
        .cfg (cfg),
        .x   (x_reg),
        .y   (y_next)
    );

    // The result register can be loaded when it is empty or being emptied
    // this cycle, and the operand register can then move on. This lets a
    // new operand transfer happen every cycle while results keep flowing.
    assign out_free      = !out_valid_reg || result.ready;
    assign in_free       = !in_valid_reg || out_free;
    assign take_in       = operand.valid && in_free;
    assign operand.ready = in_free;

    assign in_valid_next  = in_free ? operand.valid : in_valid_reg;
    assign out_valid_next = out_free ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (take_in)
            x_reg <= operand.value_in;
        if (out_free && in_valid_reg)
            y_reg <= y_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.value_out = y_reg;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for neural_activation_unit_core.
// Holds its own bit-exact model of the seven activations and checks every result transfer.
// Depends on nau_pkg, the stream interfaces and the RTL of the activation unit.
`timescale 1ns / 1ps

import nau_pkg::*;

// One outstanding result: the operand that caused it and the value it must carry.
typedef struct {
    q78_t operand;
    q78_t value;
} expected_act_t;

// Predicts the activated value of every accepted operand and checks result transfers
// against the oldest outstanding prediction.
class activation_checker;
    expected_act_t expected_values[$];
    logic [2:0]    mode;
    shape_t        shape;
    int            fails;

    function new();
        mode  = ACT_SIGMOID;
        shape = '0;
        fails = 0;
    endfunction

    function void set_config(logic reg_index, logic [31:0] data);
        if (reg_index == REG_ACT_MODE)
            mode = data[2:0];
        else
            shape = shape_t'(data[SHAPE_W-1:0]);
    endfunction

    function int pending();
        return expected_values.size();
    endfunction

    function int sat16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return int'(v);
    endfunction

    // Interpolated table value in Q0.22 for a magnitude in Q.8.
    function longint rom_point(bit from_sigmoid, int mag);
        int     idx;
        int     frac;
        int     last;
        longint lo;
        longint hi;
        idx  = mag >> 6;
        frac = mag & 63;
        last = from_sigmoid ? SIG_LAST : DEN_LAST;
        if (idx >= last)
            idx = last;
        if (from_sigmoid)
            lo = longint'(SIG_ROM[idx]);
        else
            lo = longint'(DEN_ROM[idx]);
        if (idx == last)
            return lo * 64;
        if (from_sigmoid)
            hi = longint'(SIG_ROM[idx + 1]);
        else
            hi = longint'(DEN_ROM[idx + 1]);
        return lo * 64 + (hi - lo) * frac;
    endfunction

    function int sigmoid_q8(int x);
        longint v;
        v = rom_point(1'b1, x < 0 ? -x : x);
        if (x < 0)
            v = 64'sd4194304 - v;
        return int'((v + 8192) >>> 14);
    endfunction

    function int density_q8(int x);
        longint v;
        v = rom_point(1'b0, x < 0 ? -x : x);
        return int'((v + 8192) >>> 14);
    endfunction

    function int distance(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function int snap_to(int v, int hi, int lo, int tol);
        if (distance(hi, v) <= tol)
            return hi;
        if (distance(lo, v) <= tol)
            return lo;
        return v;
    endfunction

    function q78_t predict_activation(q78_t value);
        int x;
        int y;
        int s;
        x = value;
        case (mode)
            ACT_SIGMOID:   y = sigmoid_q8(x);
            ACT_SIG_SNAP:  y = snap_to(sigmoid_q8(x), SNAP_HIGH, SNAP_LOW, int'(shape));
            ACT_BOOL_SNAP: y = snap_to(x, ONE_Q8, 0, int'(shape));
            ACT_RELU:      y = (x > 0) ? x : 0;
            ACT_LEAKY:     y = (x > 0) ? x : sat16((longint'(x) * LEAK_NUM + 32768) >>> 16);
            ACT_NOISY:
            begin
                s = sat16(longint'(x) + density_q8(x));
                y = (s > 0) ? s : 0;
            end
            ACT_PRELU:     y = (x > 0) ? x : sat16((longint'(x) * int'(shape) + 128) >>> 8);
            default:       y = x;
        endcase
        return q78_t'(y);
    endfunction

    function void note_operand(q78_t value);
        expected_act_t e;
        e.operand = value;
        e.value   = predict_activation(value);
        expected_values.push_back(e);
    endfunction

    function void check_result(q78_t actual);
        expected_act_t e;
        if (expected_values.size() == 0)
        begin
            fails++;
            if (fails <= 10)
                $display("unexpected result transfer: value_out %0d", actual);
            return;
        end
        e = expected_values.pop_front();
        if (actual !== e.value)
        begin
            fails++;
            if (fails <= 10)
                $display("value_out mismatch for value_in %0d: expected %0d, actual %0d",
                         e.operand, e.value, actual);
        end
    endfunction
endclass

module tb;

    // Mode code 7 has no member in the package; the unit passes the input through.
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    localparam int VALUE_MIN = -32768;
    localparam int VALUE_MAX = 32767;

    // Margin waited after the last result before the unit counts as idle.
    localparam int DRAIN_CYCLES = 6;

    // The slowest correct run is about 1800 transfers with idle bursts, plus
    // the register writes between phases; this limit is several times that.
    localparam int CYCLE_LIMIT = 300000;

    localparam int PHASES       = 16;
    localparam int PHASE_ITEMS  = 110;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nau_operand_if operand_ch ();
    nau_result_if  result_ch ();

    neural_activation_unit_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    activation_checker act_check;

    // Odds of an idle burst: 0 means no idling, otherwise one chance in idle_odds per
    // cycle on ready and per operand on valid. Set per phase; some phases run flat out.
    int idle_odds;
    int stall_left;
    int cycle_count;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: a run that hangs on a handshake ends here rather than running forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: ready is changed at the falling edge, in idle bursts, so that
    // stalls land on every phase of the two-stage pipeline.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1)
        begin
            stall_left      <= $urandom_range(0, 9);
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // Every result transfer is checked against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            act_check.check_result(result_ch.value_out);
    end

    // Offers one operand, optionally after an idle burst, and returns at the rising edge
    // at which the transfer takes place. Valid is left high so that a following call
    // can present the next operand without a gap.
    task automatic send_value(input q78_t value);
        int gap;
        gap = 0;
        if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1)
            gap = $urandom_range(1, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            operand_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operand_ch.valid    <= 1'b1;
        operand_ch.value_in <= value;
        do
            @(posedge clk);
        while (!operand_ch.ready);
        act_check.note_operand(value);
    endtask

    // Withdraws the operand and waits until every predicted result has arrived, then
    // lets the pipeline run empty.
    task automatic drain();
        @(negedge clk);
        operand_ch.valid <= 1'b0;
        while (act_check.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: a setup phase, then an access phase that completes when pready is high.
    task automatic write_reg(input logic reg_index, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        act_check.set_config(reg_index, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers are only ever written with the unit idle.
    task automatic configure(input logic [2:0] mode, input shape_t shape);
        drain();
        write_reg(REG_ACT_MODE, {29'd0, mode});
        write_reg(REG_SHAPE, 32'(shape));
    endtask

    // Operand mix: full range for every bit, the interesting region of the tables,
    // the neighbourhood of the snap targets, and the saturation limits.
    function automatic q78_t pick_value();
        int base;
        case ($urandom_range(0, 9))
            0, 1, 2:
                return q78_t'($urandom_range(0, 16'hFFFF));
            3, 4, 5, 6, 7:
                return q78_t'(int'($urandom_range(0, 4400)) - 2200);
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       base = 0;
                    1:       base = SNAP_LOW;
                    2:       base = SNAP_HIGH;
                    default: base = ONE_Q8;
                endcase
                base = base + int'($urandom_range(0, 80)) - 40;
                return q78_t'($urandom_range(0, 1) ? base : -base);
            end
            default:
            begin
                if ($urandom_range(0, 1))
                    return q78_t'(VALUE_MAX - int'($urandom_range(0, 3)));
                return q78_t'(VALUE_MIN + int'($urandom_range(0, 3)));
            end
        endcase
    endfunction

    // The second half of the phases walks the shape register through its extremes,
    // including values outside the range of the first half that the field still allows.
    function automatic shape_t extreme_shape(input int n);
        case (n)
            0:       return shape_t'(256);
            1:       return shape_t'(-256);
            2:       return shape_t'(0);
            3:       return shape_t'(511);
            4:       return shape_t'(-512);
            5:       return shape_t'(1);
            6:       return shape_t'(-1);
            default: return shape_t'(128);
        endcase
    endfunction

    initial
    begin
        logic [2:0] mode;
        shape_t     shape;
        int         odds;

        act_check           = new();
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        operand_ch.valid    = 1'b0;
        operand_ch.value_in = '0;
        result_ch.ready     = 1'b0;
        idle_odds           = 3;
        stall_left          = 0;
        cycle_count         = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Sigmoid at the limits of the operand and on both sides of
        // the point where the table runs out at plus or minus eight.
        configure(ACT_SIGMOID, shape_t'(0));
        send_value(q78_t'(VALUE_MIN));
        send_value(q78_t'(VALUE_MAX));
        send_value(q78_t'(2048));
        send_value(q78_t'(-2047));

        // Sigmoid snap: one lands on sigmoid(1), zero on sigmoid(0), a value in
        // between is left alone, and a negative tolerance never snaps.
        configure(ACT_SIG_SNAP, shape_t'(16));
        send_value(q78_t'(256));
        send_value(q78_t'(0));
        send_value(q78_t'(600));
        configure(ACT_SIG_SNAP, shape_t'(-5));
        send_value(q78_t'(0));

        // Boolean snap to one, to zero, and a pass-through.
        configure(ACT_BOOL_SNAP, shape_t'(32));
        send_value(q78_t'(250));
        send_value(q78_t'(10));
        send_value(q78_t'(1000));

        configure(ACT_RELU, shape_t'(0));
        send_value(q78_t'(-1));
        send_value(q78_t'(1));

        configure(ACT_LEAKY, shape_t'(0));
        send_value(q78_t'(VALUE_MIN));
        send_value(q78_t'(-1));

        // Noisy ReLU at the top of the range, at the end of the density table, and
        // with a negative operand that the density cannot lift above zero.
        configure(ACT_NOISY, shape_t'(0));
        send_value(q78_t'(VALUE_MAX));
        send_value(q78_t'(1024));
        send_value(q78_t'(-300));

        // Parametric ReLU with slopes of plus and minus one at the lowest operand; only
        // the negative slope saturates.
        configure(ACT_PRELU, shape_t'(256));
        send_value(q78_t'(VALUE_MIN));
        configure(ACT_PRELU, shape_t'(-256));
        send_value(q78_t'(VALUE_MIN));

        configure(ACT_UNUSED, shape_t'(0));
        send_value(q78_t'(-5));

        // Random part: one phase per register setting. The first half visits every
        // mode code with a random shape, the second half random modes with extreme
        // shapes. The last two phases run without any idling.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 8)
            begin
                mode  = 3'(ph);
                shape = shape_t'(int'($urandom_range(0, 512)) - 256);
            end
            else
            begin
                mode  = 3'($urandom_range(0, 6));
                shape = extreme_shape(ph - 8);
            end
            case (ph % 3)
                0:       odds = 3;
                1:       odds = 0;
                default: odds = 6;
            endcase
            configure(mode, shape);
            idle_odds = (ph >= PHASES - 2) ? 0 : odds;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Now and then the sender holds off until every result has come out,
                // so that the pipeline empties and refills from cold.
                if (i == PHASE_ITEMS / 2 && (ph == 0 || $urandom_range(0, 2) == 0))
                    drain();
                send_value(pick_value());
            end
        end

        drain();
        if (act_check.fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ neural_activation_unit_core.f @@
design/nau_pkg.sv
design/nau_stream_if.sv
design/nau_cfg_regs.sv
design/nau_act_func.sv
design/neural_activation_unit_core.sv
bench/tb.sv
